// File: rtl/cidlv_pkg.sv
// shared types, constants and codes of the can id last-value table
`default_nettype none
package cidlv_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int MAX_BYTES = 8;
    localparam int PADDR_W   = 3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

    // register index taken from paddr[2]
    localparam logic REG_STALE_TIMEOUT = 1'b0;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    typedef struct packed {
        logic        opcode;
        logic [28:0] frame_id;
        logic [63:0] frame_payload;
        logic [3:0]  frame_dlc;
        logic [3:0]  read_index;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  entry_slot;
        logic        entry_valid;
        logic [28:0] entry_id;
        logic [3:0]  entry_dlc;
        logic [63:0] entry_payload;
        logic [31:0] entry_age_ms;
        logic        entry_stale;
        logic [4:0]  entry_count;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic insert;
        logic drop;
        logic rd_req;
        logic rd_res;
    } cmd_t;

    typedef struct packed {
        logic in_read;
        logic empty;
        logic hit;
        logic last;
        logic full;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: rtl/cidlv_ctrl.sv
// sequencing state machine of the can id last-value table
`default_nettype none
module cidlv_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cidlv_pkg::sts_t sts,
    output cidlv_pkg::cmd_t    cmd
);
    import cidlv_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_UPDATE = 7'b0000100,
        S_INSERT = 7'b0001000,
        S_DROP   = 7'b0010000,
        S_RDREQ  = 7'b0100000,
        S_RDRES  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.in_read)
                    begin
                        state_next = S_RDREQ;
                    end
                    else if (sts.empty)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = S_UPDATE;
                end
                else if (sts.last)
                begin
                    state_next = sts.full ? S_DROP : S_INSERT;
                end
            end
            S_RDREQ:
            begin
                state_next = S_RDRES;
            end
            S_UPDATE, S_INSERT, S_DROP, S_RDRES:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.update = (state_reg == S_UPDATE) && sts.out_free;
    assign cmd.insert = (state_reg == S_INSERT) && sts.out_free;
    assign cmd.drop   = (state_reg == S_DROP) && sts.out_free;
    assign cmd.rd_req = (state_reg == S_RDREQ);
    assign cmd.rd_res = (state_reg == S_RDRES) && sts.out_free;

endmodule
`default_nettype wire

// File: rtl/cidlv_dp.sv
// table memory, scan compare, merge and result register
`default_nettype none
module cidlv_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cidlv_pkg::in_word_t  in_word,
    input  wire cidlv_pkg::cmd_t      cmd,
    output cidlv_pkg::sts_t           sts,
    input  wire logic [31:0]          timeout,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output cidlv_pkg::out_word_t      out_word
);
    import cidlv_pkg::*;

    function automatic logic [63:0] byte_mask(input logic [3:0] dlc);
        logic [3:0]  len;
        logic [63:0] m;
        len = (dlc > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : dlc;
        m   = '0;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            m[8*k +: 8] = {8{4'(k) < len}};
        end
        return m;
    endfunction

    // table storage
    logic [28:0] id_mem      [ENTRIES];
    logic [63:0] payload_mem [ENTRIES];
    logic [3:0]  dlc_mem     [ENTRIES];
    logic [31:0] seen_mem    [ENTRIES];

    in_word_t          word_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;
    logic [CNT_W-1:0]  ptr_reg;
    logic              cmpv_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [63:0]       old_payload_reg;
    logic [28:0]       rd_id_reg;
    logic [63:0]       rd_payload_reg;
    logic [3:0]        rd_dlc_reg;
    logic [31:0]       rd_seen_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_word_t         out_word_reg;
    out_word_t         out_word_next;

    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic              we;
    logic [63:0]       mask;
    logic [63:0]       wpayload;
    logic [3:0]        wdlc;
    logic [31:0]       age;
    logic              rd_hit_valid;
    logic [CNT_W-1:0]  last_idx;

    assign mask     = byte_mask(word_reg.frame_dlc);
    assign we       = cmd.update || cmd.insert;
    assign waddr    = cmd.update ? slot_reg : used_reg[IDX_W-1:0];
    assign raddr    = cmd.scan ? ptr_reg[IDX_W-1:0] : word_reg.read_index[IDX_W-1:0];
    assign wpayload = cmd.update ? ((old_payload_reg & ~mask) | (word_reg.frame_payload & mask))
                                 : (word_reg.frame_payload & mask);
    assign wdlc     = cmd.update ? word_reg.frame_dlc
                                 : ((word_reg.frame_dlc > 4'(MAX_BYTES)) ? 4'(MAX_BYTES)
                                                                        : word_reg.frame_dlc);
    assign age      = word_reg.now_ms - rd_seen_reg;
    assign rd_hit_valid = CNT_W'(word_reg.read_index) < used_reg;
    assign last_idx = CNT_W'(used_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            id_mem[waddr]      <= word_reg.frame_id;
            payload_mem[waddr] <= wpayload;
            dlc_mem[waddr]     <= wdlc;
            seen_mem[waddr]    <= word_reg.now_ms;
        end
        rd_id_reg      <= id_mem[raddr];
        rd_payload_reg <= payload_mem[raddr];
        rd_dlc_reg     <= dlc_mem[raddr];
        rd_seen_reg    <= seen_mem[raddr];
    end

    // input word and scan pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= in_word;
        end
        if (cmd.scan)
        begin
            slot_reg        <= cmp_idx_reg;
            old_payload_reg <= rd_payload_reg;
            cmp_idx_reg     <= ptr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            cmpv_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ptr_reg  <= '0;
            cmpv_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            ptr_reg  <= CNT_W'(ptr_reg + 1'b1);
            cmpv_reg <= ptr_reg < used_reg;
        end
    end

    assign sts.in_read  = (in_word.opcode == OP_READ);
    assign sts.empty    = (used_reg == '0);
    assign sts.full     = (used_reg == CNT_W'(ENTRIES));
    assign sts.hit      = cmpv_reg && (rd_id_reg == word_reg.frame_id);
    assign sts.last     = cmpv_reg && (CNT_W'(cmp_idx_reg) == last_idx);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign used_next = cmd.insert ? CNT_W'(used_reg + 1'b1) : used_reg;

    // result word
    always_comb
    begin
        out_word_next = '0;
        out_word_next.entry_count = used_next;
        if (cmd.update || cmd.insert)
        begin
            out_word_next.status        = cmd.update ? ST_UPDATED : ST_INSERTED;
            out_word_next.entry_slot    = 4'(waddr);
            out_word_next.entry_valid   = 1'b1;
            out_word_next.entry_id      = word_reg.frame_id;
            out_word_next.entry_dlc     = wdlc;
            out_word_next.entry_payload = wpayload;
        end
        else if (cmd.drop)
        begin
            out_word_next.status = ST_DROPPED;
        end
        else
        begin
            out_word_next.status     = ST_READ;
            out_word_next.entry_slot = word_reg.read_index;
            if (rd_hit_valid)
            begin
                out_word_next.entry_valid   = 1'b1;
                out_word_next.entry_id      = rd_id_reg;
                out_word_next.entry_dlc     = rd_dlc_reg;
                out_word_next.entry_payload = rd_payload_reg;
                out_word_next.entry_age_ms  = age;
                out_word_next.entry_stale   = age > timeout;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.update || cmd.insert || cmd.drop || cmd.rd_res)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update || cmd.insert || cmd.drop || cmd.rd_res)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
`default_nettype wire

// File: rtl/can_id_last_value_table_unit.sv
// top level of the can id last-value table: register port, controller and datapath
//
//  channel  direction  handshake           word
//  in       input      in_valid/in_stall   in_word (cidlv_pkg::in_word_t)
//  out      output     out_valid/out_stall out_word (cidlv_pkg::out_word_t)
//  cfg      input      apb psel/penable    stale_timeout_ms at byte address 0
//
//  a read result is registered from the read request and read response states; a capture
//  result from the update, insert or drop state after a scan of the table memory, one entry
//  a cycle through its registered read port
//  reset empties the table through the fill count; no clearing pass is needed
//  one word is in work at a time; the next word is taken while the result waits in
//  the output register, and a stalled output holds the finishing word in its last state
`default_nettype none
module can_id_last_value_table_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire cidlv_pkg::in_word_t           in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output cidlv_pkg::out_word_t               out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cidlv_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import cidlv_pkg::*;

    logic [31:0] timeout_reg;
    logic        reg_sel;
    cmd_t        cmd;
    sts_t        sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_STALE_TIMEOUT);
    assign prdata  = reg_sel ? timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            timeout_reg <= pwdata;
        end
    end

    cidlv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cidlv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .timeout   (timeout_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.entry_count <= CNT_W'(ENTRIES)))
        else $error("entry count beyond table size");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status == ST_DROPPED)
        |-> (out_word.entry_count == CNT_W'(ENTRIES) && !out_word.entry_valid))
        else $error("drop with room left in table");

    a_write_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_word.status == ST_UPDATED || out_word.status == ST_INSERTED))
        |-> (out_word.entry_valid && out_word.entry_age_ms == '0 && !out_word.entry_stale))
        else $error("written entry not reported fresh");

endmodule
`default_nettype wire

// File: bench/tb.sv
// testbench of the can id last-value table: a table predictor scores every result word
`default_nettype none
module tb;
    import cidlv_pkg::*;

    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_STALE_TIMEOUT, 2'b00};
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 25;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_word_t           in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predicted table contents
    logic [28:0]        tbl_id [ENTRIES];
    logic [63:0]        tbl_payload [ENTRIES];
    logic [3:0]         tbl_dlc [ENTRIES];
    logic [31:0]        tbl_seen [ENTRIES];
    int unsigned        tbl_used = 0;
    logic [31:0]        timeout_ms = TIMEOUT_RESET;

    out_word_t          pending_results [$];
    int                 fail_count = 0;
    int                 burst_left = 0;
    logic [31:0]        cur_now = '0;

    logic               hold_req = 1'b0;
    logic               hold_ack = 1'b0;
    int                 hold_left = 0;
    rx_mode_t           rx_mode = RX_FREE;
    int                 mode_left = 0;

    can_id_last_value_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t slot_view(status_t st, int unsigned slot, logic valid,
                                            logic [31:0] now);
        out_word_t   r;
        logic [31:0] age;
        r = '0;
        r.status = st;
        r.entry_slot = slot[3:0];
        r.entry_count = tbl_used[4:0];
        if (valid)
        begin
            age = now - tbl_seen[slot];
            r.entry_valid = 1'b1;
            r.entry_id = tbl_id[slot];
            r.entry_dlc = tbl_dlc[slot];
            r.entry_payload = tbl_payload[slot];
            r.entry_age_ms = age;
            r.entry_stale = (age > timeout_ms);
        end
        return r;
    endfunction

    function automatic out_word_t table_apply(in_word_t w);
        int unsigned len;
        logic [63:0] mask;
        int          hit;
        int unsigned slot;
        if (w.opcode == OP_READ)
            return slot_view(ST_READ, w.read_index, w.read_index < tbl_used, w.now_ms);
        len = (w.frame_dlc < MAX_BYTES) ? w.frame_dlc : MAX_BYTES;
        mask = (len >= MAX_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        hit = -1;
        for (int i = 0; i < tbl_used; i++)
            if (hit < 0 && tbl_id[i] == w.frame_id)
                hit = i;
        if (hit >= 0)
        begin
            slot = hit;
            tbl_payload[slot] = (tbl_payload[slot] & ~mask) | (w.frame_payload & mask);
            tbl_dlc[slot] = w.frame_dlc;
            tbl_seen[slot] = w.now_ms;
            return slot_view(ST_UPDATED, slot, 1'b1, w.now_ms);
        end
        if (tbl_used < ENTRIES)
        begin
            slot = tbl_used;
            tbl_id[slot] = w.frame_id;
            tbl_dlc[slot] = len[3:0];
            tbl_seen[slot] = w.now_ms;
            tbl_payload[slot] = w.frame_payload & mask;
            tbl_used++;
            return slot_view(ST_INSERTED, slot, 1'b1, w.now_ms);
        end
        return slot_view(ST_DROPPED, 0, 1'b0, w.now_ms);
    endfunction

    function automatic in_word_t frame_word(logic op, logic [28:0] id, logic [63:0] data,
                                            logic [3:0] dlc, logic [3:0] idx,
                                            logic [31:0] now);
        in_word_t w;
        w.opcode = op;
        w.frame_id = id;
        w.frame_payload = data;
        w.frame_dlc = dlc;
        w.read_index = idx;
        w.now_ms = now;
        return w;
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        w.opcode = ($urandom_range(0, 3) == 0) ? OP_READ : OP_CAPTURE;
        w.frame_id = 29'($urandom);
        // mostly known identifiers so that updates dominate
        if (w.opcode == OP_CAPTURE && tbl_used > 0 && $urandom_range(0, 9) != 0)
            w.frame_id = tbl_id[$urandom_range(0, tbl_used - 1)];
        w.frame_payload = {$urandom, $urandom};
        w.frame_dlc = 4'($urandom_range(0, 15));
        w.read_index = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 15) == 0)
            cur_now = $urandom;
        else
            cur_now = cur_now + $urandom_range(0, 2500);
        w.now_ms = cur_now;
        return w;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        out_word_t want;
        logic      bad;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(table_apply(in_word));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result word with nothing pending at %0t", $time);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad = (out_word.status !== want.status)
                        || (out_word.entry_slot !== want.entry_slot)
                        || (out_word.entry_valid !== want.entry_valid)
                        || (out_word.entry_id !== want.entry_id)
                        || (out_word.entry_dlc !== want.entry_dlc)
                        || (out_word.entry_payload !== want.entry_payload)
                        || (out_word.entry_age_ms !== want.entry_age_ms)
                        || (out_word.entry_stale !== want.entry_stale)
                        || (out_word.entry_count !== want.entry_count);
                    if (bad)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch at %0t", $time);
                            $display("  exp st=%0d slot=%0d v=%0d id=%h dlc=%0d pl=%h age=%h s=%0d n=%0d",
                                     want.status, want.entry_slot, want.entry_valid,
                                     want.entry_id, want.entry_dlc, want.entry_payload,
                                     want.entry_age_ms, want.entry_stale, want.entry_count);
                            $display("  got st=%0d slot=%0d v=%0d id=%h dlc=%0d pl=%h age=%h s=%0d n=%0d",
                                     out_word.status, out_word.entry_slot, out_word.entry_valid,
                                     out_word.entry_id, out_word.entry_dlc,
                                     out_word.entry_payload, out_word.entry_age_ms,
                                     out_word.entry_stale, out_word.entry_count);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_FREE:     out_stall <= 1'b0;
                RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((mode_left % 5) < 2);
            endcase
        end
    end

    // all tasks start and end just after a falling edge
    task automatic send_word(in_word_t w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= TIMEOUT_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        timeout_ms = value;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            if (fail_count < 10)
                $display("timeout readback exp %h got %h", value, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_capture_cases();
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd0, 32'd0));
        send_word(frame_word(OP_READ, 29'h1FFF_FFFF, '1, 4'd15, 4'd15, 32'hFFFF_FFFF));
        send_word(frame_word(OP_CAPTURE, 29'd0, '1, 4'd0, 4'd0, 32'd100));
        send_word(frame_word(OP_CAPTURE, 29'h1FFF_FFFF, '1, 4'd15, 4'd15, 32'd200));
        send_word(frame_word(OP_CAPTURE, 29'd0, 64'h1122_3344_5566_7788, 4'd3, 4'd0, 32'd300));
        send_word(frame_word(OP_CAPTURE, 29'h1FFF_FFFF, 64'd0, 4'd12, 4'd0, 32'd400));
        send_word(frame_word(OP_CAPTURE, 29'd0, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 4'd0, 32'd500));
        send_word(frame_word(OP_CAPTURE, 29'h0ABC_DEF, 64'h0123_4567_89AB_CDEF, 4'd9, 4'd0,
                             32'hFFFF_FFFF));
        send_word(frame_word(OP_CAPTURE, 29'd5, 64'hDEAD_BEEF_CAFE_F00D, 4'd8, 4'd0, 32'd0));
        send_word(frame_word(OP_CAPTURE, 29'd5, 64'd0, 4'd7, 4'd0, 32'd1));
        send_word(frame_word(OP_CAPTURE, 29'd5, '1, 4'd1, 4'd0, 32'd2));
        wait_idle();
    endtask

    task automatic test_age_and_stale();
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd2, 32'h10));
        // exactly at the timeout, then one past it
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd0, 32'd2500));
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd0, 32'd2501));
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd1, 32'd0));
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd3, 32'd2));
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd4, 32'd2));
        send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'd15, 32'd0));
        wait_idle();
    endtask

    task automatic test_input_backpressure();
        hold_req <= ~hold_req;
        burst_left = 1000;
        repeat (16) send_word(rand_word());
        wait_idle();
    endtask

    task automatic test_full_table();
        repeat (20)
            send_word(frame_word(OP_CAPTURE, 29'($urandom), {$urandom, $urandom},
                                 4'($urandom_range(0, 15)), 4'd0, $urandom));
        repeat (10)
            send_word(frame_word(OP_CAPTURE, tbl_id[$urandom_range(0, ENTRIES - 1)],
                                 {$urandom, $urandom}, 4'($urandom_range(0, 15)), 4'd0,
                                 $urandom));
        for (int i = 0; i < ENTRIES; i++)
            send_word(frame_word(OP_READ, 29'd0, 64'd0, 4'd0, 4'(i), $urandom));
        wait_idle();
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_word(rand_word());
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_capture_cases();
        test_age_and_stale();
        test_input_backpressure();
        write_timeout(32'd0);
        test_random_traffic(300);
        test_full_table();
        write_timeout(32'hFFFF_FFFF);
        test_random_traffic(300);
        write_timeout($urandom_range(1, 5000));
        test_random_traffic(300);
        write_timeout(TIMEOUT_RESET);
        test_random_traffic(300);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/cidlv_pkg.sv
rtl/cidlv_ctrl.sv
rtl/cidlv_dp.sv
rtl/can_id_last_value_table_unit.sv
bench/tb.sv
